// ===== rtl/gsf_pkg.sv =====
// Shared types, constants and helper functions of the gzip stored-block framer.
`timescale 1ns / 1ps

package gsf_pkg;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam int BLK_LEN_W = 16;
    localparam logic [31:0] MAX_BLOCK_BYTES = 32'd65535;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    localparam int GZ_HEAD_LEN = 10;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        JOB_START,
        JOB_DATA,
        JOB_DROP
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic                   blk_hdr;
        logic                   bfinal;
        logic [BLK_LEN_W-1:0]   blk_len;
        logic [7:0]             data;
        logic                   trailer;
        logic [31:0]            crc;
        logic [31:0]            len;
    } t_job;

    typedef enum logic [2:0] {
        BK_NEXT,
        BK_GZHDR,
        BK_BLKHDR,
        BK_DATA,
        BK_TRAIL,
        BK_DROP
    } t_bk_state;

    // Fixed gzip member header: deflate, no flags, no mtime, unknown OS
    function automatic logic [7:0] gz_head_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h1f;
            4'd1:    b = 8'h8b;
            4'd2:    b = 8'h08;
            4'd9:    b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Reflected CRC-32, one byte, bitwise
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/gsf_if.sv =====
// Channel interfaces of the framer: input requests, output bytes, length register writes.
`timescale 1ns / 1ps

interface gsf_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface gsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       member_done;
    logic       overrun;

    modport source (output valid, output out_byte, output run_last,
                    output member_done, output overrun, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input member_done, input overrun, output ready);
endinterface

interface gsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gsf_front.sv =====
// Front end: accepts requests, keeps CRC and length state, classifies each request into a job.
`timescale 1ns / 1ps

module gsf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gsf_in_if.sink        i_in,
    gsf_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output gsf_pkg::t_job o_job
);

    logic [31:0]                  r_len;
    logic [31:0]                  r_crc;
    logic [31:0]                  r_taken;
    logic [gsf_pkg::BLK_LEN_W-1:0] r_blk_rem;
    logic                         r_open;

    logic [31:0]                  n_crc;
    logic [31:0]                  n_taken;
    logic [gsf_pkg::BLK_LEN_W-1:0] n_blk_rem;
    logic                         n_open;

    logic                         accept;
    logic [31:0]                  left;
    logic                         fits;
    logic [gsf_pkg::BLK_LEN_W-1:0] size;
    logic                         need_hdr;
    logic [31:0]                  taken_inc;
    logic [31:0]                  crc_new;
    logic [gsf_pkg::BLK_LEN_W-1:0] rem_base;
    logic                         closing;
    logic                         dropping;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_q_full;
    assign o_push      = accept;

    assign left      = r_len - r_taken;
    assign fits      = (left <= gsf_pkg::MAX_BLOCK_BYTES);
    assign size      = fits ? left[gsf_pkg::BLK_LEN_W-1:0]
                            : gsf_pkg::MAX_BLOCK_BYTES[gsf_pkg::BLK_LEN_W-1:0];
    assign need_hdr  = (r_blk_rem == '0);
    assign taken_inc = r_taken + 32'd1;
    assign crc_new   = gsf_pkg::crc_byte(r_crc, i_in.data_byte);
    assign rem_base  = need_hdr ? size : r_blk_rem;
    assign closing   = (taken_inc == r_len);
    assign dropping  = !r_open || (r_taken >= r_len);

    always_comb begin
        n_crc     = r_crc;
        n_taken   = r_taken;
        n_blk_rem = r_blk_rem;
        n_open    = r_open;

        o_job         = '0;
        o_job.kind    = gsf_pkg::JOB_DROP;
        o_job.data    = i_in.data_byte;
        o_job.blk_len = size;
        o_job.bfinal  = fits;

        case (i_in.command)
            gsf_pkg::CMD_START: begin
                o_job.kind    = gsf_pkg::JOB_START;
                // empty member closes at once with an all-zero trailer
                o_job.trailer = (r_len == '0);
                n_crc         = gsf_pkg::CRC_INIT;
                n_taken       = '0;
                n_blk_rem     = '0;
                n_open        = (r_len != '0);
            end
            gsf_pkg::CMD_DATA: begin
                if (!dropping) begin
                    o_job.kind    = gsf_pkg::JOB_DATA;
                    o_job.blk_hdr = need_hdr;
                    o_job.trailer = closing;
                    o_job.crc     = crc_new ^ gsf_pkg::CRC_INIT;
                    o_job.len     = taken_inc;
                    n_crc         = crc_new;
                    n_taken       = taken_inc;
                    n_blk_rem     = closing ? '0 : rem_base - 1'b1;
                    n_open        = !closing;
                end
            end
            default: begin
                o_job.kind = gsf_pkg::JOB_DROP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_crc     <= gsf_pkg::CRC_INIT;
            r_taken   <= '0;
            r_blk_rem <= '0;
            r_open    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_len <= i_cfg.data;
            end
            if (accept) begin
                r_crc     <= n_crc;
                r_taken   <= n_taken;
                r_blk_rem <= n_blk_rem;
                r_open    <= n_open;
            end
        end
    end

endmodule

// ===== rtl/gsf_queue.sv =====
// Short job queue decoupling the front end from the byte emitter.
`timescale 1ns / 1ps

module gsf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gsf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output gsf_pkg::t_job o_head
);

    gsf_pkg::t_job             r_mem [gsf_pkg::Q_DEPTH];
    logic [gsf_pkg::Q_AW-1:0]  r_wr;
    logic [gsf_pkg::Q_AW-1:0]  r_rd;
    logic [gsf_pkg::Q_AW:0]    r_count;

    logic                      do_pop;

    assign o_full       = (r_count == (gsf_pkg::Q_AW+1)'(gsf_pkg::Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/gsf_back.sv =====
// Back end: walks each queued job byte by byte into a registered output stage.
`timescale 1ns / 1ps

module gsf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  gsf_pkg::t_job i_head,
    output logic          o_pop,
    gsf_out_if.source     o_out
);

    gsf_pkg::t_bk_state r_state;
    gsf_pkg::t_bk_state n_state;
    gsf_pkg::t_bk_state cur;
    logic [3:0]         r_idx;
    logic [3:0]         n_idx;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_run_last;
    logic               r_member_done;
    logic               r_overrun;

    logic               step;
    logic               job_end;
    logic [7:0]         byte_sel;
    logic               done_sel;
    logic               ovr_sel;
    logic [31:0]        trail_word;

    assign step  = i_head_valid && (!r_out_valid || o_out.ready);
    assign o_pop = step && job_end;

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.run_last    = r_run_last;
    assign o_out.member_done = r_member_done;
    assign o_out.overrun     = r_overrun;

    assign trail_word = r_idx[2] ? i_head.len : i_head.crc;

    always_comb begin
        // a fresh job picks its first phase from its kind
        cur = r_state;
        if (r_state == gsf_pkg::BK_NEXT) begin
            case (i_head.kind)
                gsf_pkg::JOB_START: cur = gsf_pkg::BK_GZHDR;
                gsf_pkg::JOB_DATA:  cur = i_head.blk_hdr ? gsf_pkg::BK_BLKHDR
                                                         : gsf_pkg::BK_DATA;
                default:            cur = gsf_pkg::BK_DROP;
            endcase
        end

        n_state  = cur;
        n_idx    = r_idx + 4'd1;
        job_end  = 1'b0;
        byte_sel = 8'h00;
        done_sel = 1'b0;
        ovr_sel  = 1'b0;

        case (cur)
            gsf_pkg::BK_GZHDR: begin
                byte_sel = gsf_pkg::gz_head_byte(r_idx);
                if (r_idx == 4'(gsf_pkg::GZ_HEAD_LEN - 1)) begin
                    n_idx = '0;
                    if (i_head.trailer) begin
                        n_state = gsf_pkg::BK_TRAIL;
                    end else begin
                        job_end = 1'b1;
                    end
                end
            end
            gsf_pkg::BK_BLKHDR: begin
                case (r_idx)
                    4'd0:    byte_sel = {7'd0, i_head.bfinal};
                    4'd1:    byte_sel = i_head.blk_len[7:0];
                    4'd2:    byte_sel = i_head.blk_len[15:8];
                    4'd3:    byte_sel = ~i_head.blk_len[7:0];
                    default: byte_sel = ~i_head.blk_len[15:8];
                endcase
                if (r_idx == 4'd4) begin
                    n_idx   = '0;
                    n_state = gsf_pkg::BK_DATA;
                end
            end
            gsf_pkg::BK_DATA: begin
                byte_sel = i_head.data;
                n_idx    = '0;
                if (i_head.trailer) begin
                    n_state = gsf_pkg::BK_TRAIL;
                end else begin
                    job_end = 1'b1;
                end
            end
            gsf_pkg::BK_TRAIL: begin
                case (r_idx[1:0])
                    2'd0:    byte_sel = trail_word[7:0];
                    2'd1:    byte_sel = trail_word[15:8];
                    2'd2:    byte_sel = trail_word[23:16];
                    default: byte_sel = trail_word[31:24];
                endcase
                if (r_idx == 4'd7) begin
                    done_sel = 1'b1;
                    job_end  = 1'b1;
                end
            end
            default: begin
                // dropped payload byte
                ovr_sel = 1'b1;
                job_end = 1'b1;
            end
        endcase

        if (job_end) begin
            n_state = gsf_pkg::BK_NEXT;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gsf_pkg::BK_NEXT;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state     <= n_state;
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte    <= byte_sel;
            r_run_last    <= job_end;
            r_member_done <= done_sel;
            r_overrun     <= ovr_sel;
        end
    end

endmodule

// ===== rtl/gzip_stored_block_framer.sv =====
// Top level of the gzip stored-block framer.
// Wraps a payload of stream_length bytes as one gzip member of stored deflate blocks.
// A start request (command 0) resets the CRC and byte count and yields the 10-byte gzip
// header, plus the 8-byte trailer when the length is zero. Each payload request (command 1)
// yields its byte, preceded by a 5-byte block header at every block boundary (blocks of up
// to 65535 bytes) and followed by the CRC-32 and length trailer after the last byte. A
// payload byte with no open member or beyond the length yields one zero byte with overrun
// set. Requests are taken one per cycle while the 4-entry job queue has room; the output
// side emits one byte per cycle while its sink is ready. A request yields 1 byte for a
// plain byte, 6 at a block boundary, 9 or 14 when closing the member, 10 or 18 for a start.
// The output byte rate bounds sustained throughput. Write stream_length only while idle.
`timescale 1ns / 1ps

module gzip_stored_block_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsf_in_if.sink     i_in,
    gsf_cfg_if.sink    i_cfg,
    gsf_out_if.source  o_out
);

    logic          push;
    gsf_pkg::t_job job;
    logic          q_full;
    logic          head_valid;
    gsf_pkg::t_job head;
    logic          pop;

    gsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job)
    );

    gsf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    gsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
